/* sv/pota_pkg.sv */
package pota_pkg;

    // Fixed-point angle constants, Q3.28 radians.
    localparam logic [30:0] Q_HALF_PI   = 31'd421657428;
    localparam logic [30:0] Q_PI        = 31'd843314857;
    localparam logic [30:0] Q_3HALF_PI  = 31'd1264972285;
    localparam logic [30:0] Q_TWO_PI    = 31'd1686629713;

    localparam int CORDIC_STAGES = 28;
    localparam int NORM_STEPS    = 6;
    localparam int XW            = 46;   // CORDIC vector width
    localparam int MW            = 42;   // magnitude width during normalization
    localparam int AW            = 34;   // arc bound width

    // Configuration register indexes.
    localparam logic CFG_CTOL = 1'b0;
    localparam logic CFG_ATOL = 1'b1;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] start_angle;
        logic signed [31:0] end_angle;
        logic               reverse_dir;
    } t_in_word;

    typedef struct packed {
        logic        on_arc;
        logic [30:0] point_angle;
    } t_out_word;

    // Per-item facts that ride along with the CORDIC vector.
    typedef struct packed {
        logic                 near;
        logic [30:0]          near_ang;
        logic                 neg;
        logic                 zero;
        logic signed [AW-1:0] lo;
        logic signed [AW-1:0] hi;
    } t_side;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [MW-1:0]        m;
        t_side                side;
    } t_cls;

    // Rounded atan(2^-i) in Q3.28.
    function automatic logic [27:0] atan_tab(input int i);
        logic [27:0] v;
        unique case (i)
            0:  v = 28'd210828714;
            1:  v = 28'd124459457;
            2:  v = 28'd65760959;
            3:  v = 28'd33381290;
            4:  v = 28'd16755422;
            5:  v = 28'd8385879;
            6:  v = 28'd4193963;
            7:  v = 28'd2097109;
            8:  v = 28'd1048571;
            9:  v = 28'd524287;
            10: v = 28'd262144;
            11: v = 28'd131072;
            12: v = 28'd65536;
            13: v = 28'd32768;
            14: v = 28'd16384;
            15: v = 28'd8192;
            16: v = 28'd4096;
            17: v = 28'd2048;
            18: v = 28'd1024;
            19: v = 28'd512;
            20: v = 28'd256;
            21: v = 28'd128;
            22: v = 28'd64;
            23: v = 28'd32;
            24: v = 28'd16;
            25: v = 28'd8;
            26: v = 28'd4;
            27: v = 28'd2;
            28: v = 28'd1;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/pota_front.sv */
module pota_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pota_pkg::t_in_word i_data,
    input  logic [15:0]       i_ctol,
    input  logic [23:0]       i_atol,
    output logic              o_push,
    input  logic              i_full,
    output pota_pkg::t_cls    o_cls
);
    import pota_pkg::*;

    logic                 r_v;
    logic signed [32:0]   r_dx, r_dy;
    logic signed [31:0]   r_st, r_en;

    logic signed [32:0]   adx_s, ydir;
    logic [32:0]          adx, ay;
    logic                 neg;
    logic signed [AW-1:0] st_w, en_w, en_l;

    assign o_push  = r_v && !i_full;
    assign o_ready = !r_v || !i_full;

    // First stage: differences and the start/end swap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_dx <= 33'(i_data.point_x) - 33'(i_data.center_x);
            r_dy <= 33'(i_data.point_y) - 33'(i_data.center_y);
            r_st <= i_data.reverse_dir ? i_data.end_angle : i_data.start_angle;
            r_en <= i_data.reverse_dir ? i_data.start_angle : i_data.end_angle;
        end
    end

    // Classification: near-vertical test, half-plane turn and arc bounds.
    always_comb begin
        neg   = r_dx[32];
        adx_s = neg ? -r_dx : r_dx;
        adx   = adx_s;
        ydir  = neg ? -r_dy : r_dy;
        ay    = ydir[32] ? 33'(-ydir) : 33'(ydir);
        st_w  = AW'(r_st);
        en_w  = AW'(r_en);
        en_l  = (en_w < st_w) ? en_w + $signed({3'b0, Q_TWO_PI}) : en_w;

        o_cls.x             = XW'(adx_s);
        o_cls.y             = XW'(ydir);
        o_cls.m             = MW'((adx > ay) ? adx : ay);
        o_cls.side.near     = adx < {17'b0, i_ctol};
        o_cls.side.near_ang = (r_dy < $signed({17'b0, i_ctol})) ? Q_PI : 31'd0;
        o_cls.side.neg      = neg;
        o_cls.side.zero     = (adx == 33'd0) && (ay == 33'd0);
        o_cls.side.lo       = st_w - $signed({10'b0, i_atol});
        o_cls.side.hi       = en_l + $signed({10'b0, i_atol});
    end

endmodule

/* sv/pota_fifo.sv */
module pota_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pota_pkg::t_cls i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pota_pkg::t_cls o_data
);
    import pota_pkg::*;

    t_cls       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    // Two-entry queue between classification and the CORDIC pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

/* sv/pota_back.sv */
module pota_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  pota_pkg::t_cls    i_cls,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output pota_pkg::t_out_word o_data
);
    import pota_pkg::*;

    localparam int NS = NORM_STEPS;
    localparam int CS = CORDIC_STAGES;

    logic                 en;

    // Normalization stages: index 0 holds the word taken from the queue.
    logic                 r_nv [NS+1];
    t_cls                 r_n  [NS+1];

    // CORDIC stages: index 0 holds the normalized vector.
    logic                 r_cv [CS+1];
    logic signed [XW-1:0] r_cx [CS+1];
    logic signed [XW-1:0] r_cy [CS+1];
    logic signed [31:0]   r_cz [CS+1];
    t_side                r_cs [CS+1];

    logic                 r_av;
    logic [30:0]          r_ang;
    t_side                r_as;
    logic                 r_ov;
    t_out_word            r_out;

    logic signed [33:0]   ang_w;
    logic [30:0]          ang_c;
    logic signed [AW:0]   a0, a2, lo_e, hi_e;

    assign en      = !r_ov || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv[0] <= 1'b0;
        end else if (en) begin
            r_nv[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_n[0] <= i_cls;
    end

    // Binary search for the shift that brings the larger part to 2^40.
    for (genvar s = 0; s < NS; s++) begin : g_norm
        localparam int K = 32 >> s;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[s+1] <= 1'b0;
            end else if (en) begin
                r_nv[s+1] <= r_nv[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_n[s+1].side <= r_n[s].side;
                if (r_n[s].m < (MW'(1) << (41 - K))) begin
                    r_n[s+1].x <= r_n[s].x <<< K;
                    r_n[s+1].y <= r_n[s].y <<< K;
                    r_n[s+1].m <= r_n[s].m << K;
                end else begin
                    r_n[s+1].x <= r_n[s].x;
                    r_n[s+1].y <= r_n[s].y;
                    r_n[s+1].m <= r_n[s].m;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_nv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= r_n[NS].x;
            r_cy[0] <= r_n[NS].y;
            r_cz[0] <= 32'sd0;
            r_cs[0] <= r_n[NS].side;
        end
    end

    // Vectoring CORDIC, one rotation per stage.
    for (genvar i = 0; i < CS; i++) begin : g_cordic
        localparam logic signed [31:0] TAB = $signed({4'b0, atan_tab(i)});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cs[i+1] <= r_cs[i];
                if (!r_cy[i][XW-1]) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + TAB;
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - TAB;
                end
            end
        end
    end

    // Compass angle with clamping, or the near-vertical answer.
    always_comb begin
        ang_w = (r_cs[CS].neg ? $signed({3'b0, Q_3HALF_PI}) : $signed({3'b0, Q_HALF_PI}))
              - (r_cs[CS].zero ? 34'sd0 : 34'(r_cz[CS]));
        if (ang_w < 0)
            ang_c = 31'd0;
        else if (ang_w > $signed({3'b0, Q_TWO_PI}))
            ang_c = Q_TWO_PI;
        else
            ang_c = ang_w[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (en) begin
            r_av <= r_cv[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang <= r_cs[CS].near ? r_cs[CS].near_ang : ang_c;
            r_as  <= r_cs[CS];
        end
    end

    // Arc test at the angle and one turn above it.
    always_comb begin
        a0   = $signed({4'b0, r_ang});
        a2   = a0 + $signed({4'b0, Q_TWO_PI});
        lo_e = (AW+1)'(r_as.lo);
        hi_e = (AW+1)'(r_as.hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.point_angle <= r_ang;
            r_out.on_arc      <= (a0 >= lo_e && a0 <= hi_e) || (a2 >= lo_e && a2 <= hi_e);
        end
    end

endmodule

/* sv/point_on_arc_test.sv */
// Point-on-arc test. Each input word gives a point, an arc center, start and
// end angles (Q3.28) and a direction flag; each output word gives the compass
// angle from center to point and whether it lies on the arc within the
// angular tolerance. One word is accepted per clock cycle unless a stalled
// output has filled the queue. An accepted word passes through the unrolled
// pipeline: one front register, the queue, an input register and 6
// normalization stages, a vector register and 28 CORDIC stages, then the
// angle and arc-test registers. A stalled output holds the whole back
// part. The two tolerance registers are written through a plain write port
// and may only change while the block is idle.
module point_on_arc_test (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pota_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pota_pkg::t_out_word  o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [23:0]          i_cfg_wdata
);
    import pota_pkg::*;

    logic [15:0] r_ctol;
    logic [23:0] r_atol;
    logic        push, full, pop, empty;
    t_cls        f_cls, q_cls;

    // Tolerance registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctol <= 16'd66;
            r_atol <= 24'd268435;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CTOL: r_ctol <= i_cfg_wdata[15:0];
                CFG_ATOL: r_atol <= i_cfg_wdata;
                default:  r_atol <= r_atol;
            endcase
        end
    end

    pota_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_data(i_in_data),
        .i_ctol(r_ctol), .i_atol(r_atol),
        .o_push(push), .i_full(full), .o_cls(f_cls)
    );

    pota_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(f_cls), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q_cls)
    );

    pota_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_cls(q_cls), .o_pop(pop),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_data(o_out_data)
    );

endmodule

/* sv/pota_checker.sv */
module pota_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pota_pkg::t_out_word o_out_data
);
    import pota_pkg::*;

    logic [7:0] r_pending;

    // Words accepted at the input and not yet taken at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 8'd0;
        end else begin
            r_pending <= r_pending + 8'(i_in_valid && o_in_ready)
                       - 8'(o_out_valid && i_out_ready);
        end
    end

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("output valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // The angle never leaves [0, 2pi].
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.point_angle <= Q_TWO_PI)
        else $error("angle out of range");

    // Nothing comes out without an earlier accepted word.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 8'd0)
        else $error("output valid without cause");

endmodule

bind point_on_arc_test pota_checker u_pota_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_out_data(o_out_data)
);

/* dv/point_on_arc_test_tb.sv */
module point_on_arc_test_tb;
    import pota_pkg::*;

    // Standalone angle constants, Q3.28 radians.
    localparam longint ANG_HALF_PI   = 64'sd421657428;
    localparam longint ANG_PI        = 64'sd843314857;
    localparam longint ANG_3HALF_PI  = 64'sd1264972285;
    localparam longint ANG_TWO_PI    = 64'sd1686629713;
    localparam int     N_RANDOM      = 1330;
    localparam int     DRAIN_CYCLES  = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [23:0] i_cfg_wdata;

    point_on_arc_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor copy of the tolerance registers.
    longint    ctol_model;
    longint    atol_model;
    t_out_word angle_expect_q[$];
    int        n_errors;
    int        n_words_out;
    int        n_hits;
    bit        no_idle;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    // Floor shift of a signed value.
    function automatic longint fshift(longint v, int k);
        return v >>> k;
    endfunction

    // Arctangent of y/x for x >= 0 by vectoring rotations, Q3.28.
    function automatic longint vector_atan(longint x, longint y);
        longint ay;
        longint mag;
        longint z;
        longint xs;
        longint ys;
        longint tab[29];
        tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
                16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4,
                2, 1};
        ay = (y < 0) ? -y : y;
        mag = (x > ay) ? x : ay;
        z = 0;
        if (mag == 0) return 0;
        while (mag < (64'sd1 <<< 40)) begin
            mag = mag <<< 1;
            x = x <<< 1;
            y = y <<< 1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 29; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - tab[i];
            end
        end
        return z;
    endfunction

    // Expected output word for one input word.
    function automatic t_out_word arc_predict(t_in_word w);
        longint    dx;
        longint    dy;
        longint    adx;
        longint    ang;
        longint    t;
        longint    a0;
        longint    a1;
        longint    lo;
        longint    hi;
        t_out_word r;
        dx = longint'(w.point_x) - longint'(w.center_x);
        dy = longint'(w.point_y) - longint'(w.center_y);
        adx = (dx < 0) ? -dx : dx;
        if (adx < ctol_model) begin
            ang = (dy < ctol_model) ? ANG_PI : 0;
        end else begin
            t = (dx < 0) ? vector_atan(-dx, -dy) : vector_atan(dx, dy);
            ang = (dx >= ctol_model) ? (ANG_HALF_PI - t) : (ANG_3HALF_PI - t);
            if (ang < 0) ang = 0;
            if (ang > ANG_TWO_PI) ang = ANG_TWO_PI;
        end
        a0 = longint'(w.start_angle);
        a1 = longint'(w.end_angle);
        if (w.reverse_dir) begin
            t = a0;
            a0 = a1;
            a1 = t;
        end
        if (a1 < a0) a1 = a1 + ANG_TWO_PI;
        lo = a0 - atol_model;
        hi = a1 + atol_model;
        r.on_arc = (ang >= lo && ang <= hi) ||
                   (ang + ANG_TWO_PI >= lo && ang + ANG_TWO_PI <= hi);
        r.point_angle = ang[30:0];
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 27);
    endfunction

    // Output side: random stalls and comparison against the oldest expectation.
    initial begin
        i_out_ready = 1'b0;
        n_errors = 0;
        n_words_out = 0;
        n_hits = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (angle_expect_q.size() == 0) begin
                    $error("unexpected output word %h", o_out_data);
                    n_errors++;
                end else begin
                    t_out_word e;
                    e = angle_expect_q.pop_front();
                    n_words_out++;
                    n_hits += int'(o_out_data.on_arc);
                    if (o_out_data.on_arc !== e.on_arc) begin
                        $error("on_arc: expected %0d, got %0d", e.on_arc,
                               o_out_data.on_arc);
                        n_errors++;
                    end
                    if (o_out_data.point_angle !== e.point_angle) begin
                        $error("point_angle: expected %0d, got %0d",
                               e.point_angle, o_out_data.point_angle);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    // Send one word, holding it until accepted; queue its expectation.
    // Valid stays high after acceptance so that words can follow back to back;
    // it drops only in an idle cycle or when the caller stops sending.
    task automatic send_word(t_in_word w, bit typed, t_out_word typed_res);
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        angle_expect_q.push_back(typed ? typed_res : arc_predict(w));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Wait for the pipeline to empty, then write one register.
    task automatic write_reg(logic idx, logic [23:0] val);
        i_in_valid <= 1'b0;
        while (angle_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CTOL) ctol_model = longint'(val[15:0]);
        else atol_model = longint'(val);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(7) == 0) return $urandom;
        return 32'($signed($urandom_range(32'd1686629713 + 32'd2000000)) - 1000000);
    endfunction

    // Directed rows: point, center, arc, direction, and a typed result where obvious.
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_row;

    t_row      arc_rows[$];
    t_in_word  w;
    int        sent;

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CTOL;
        i_cfg_wdata = '0;
        no_idle = 1'b0;
        ctol_model = 66;
        atol_model = 268435;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Near vertical above: angle 0, arc covers it.
        arc_rows.push_back('{'{0, 100000, 0, 0, 0, 32'd1000, 1'b0}, 1, '{1'b1, 31'd0}});
        // Near vertical below: angle pi, arc excludes it.
        arc_rows.push_back('{'{10, -100000, 0, 0, 0, 32'd1000, 1'b0}, 1,
                             '{1'b0, 31'd843314857}});
        // Coincident point counts as below.
        arc_rows.push_back('{'{5, 5, 5, 5, 0, 0, 1'b1}, 1, '{1'b0, 31'd843314857}});
        // Extremes of coordinates and angles.
        arc_rows.push_back('{'{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 1'b0}, 0, '0});
        arc_rows.push_back('{'{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 1'b1}, 0, '0});
        arc_rows.push_back('{'{32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 1'b0}, 0, '0});
        arc_rows.push_back('{'{65536, 0, 0, 0, 0, 32'd843314857, 1'b0}, 0, '0});
        arc_rows.push_back('{'{-65536, 0, 0, 0, 0, 32'd843314857, 1'b1}, 0, '0});
        arc_rows.push_back('{'{-65536, 1, 0, 0, 32'd843314857, 0, 1'b0}, 0, '0});
        arc_rows.push_back('{'{-65536, -1, 0, 0, 32'd1686629713, 0, 1'b0}, 0, '0});
        arc_rows.push_back('{'{65536, 65536, 0, 0, 32'hf0000000, 32'h10000000, 1'b0},
                           0, '0});
        arc_rows.push_back('{'{65536, -65536, 0, 0, 32'h10000000, 32'h0fffffff, 1'b1},
                           0, '0});
        foreach (arc_rows[i]) send_word(arc_rows[i].w, arc_rows[i].typed, arc_rows[i].res);

        // Zero tolerances: dx of zero goes through the rotation path.
        write_reg(CFG_CTOL, 24'd0);
        write_reg(CFG_ATOL, 24'd0);
        send_word('{0, 0, 0, 0, 0, 0, 1'b0}, 0, '0);
        send_word('{0, 65536, 0, 0, 0, 0, 1'b0}, 0, '0);
        send_word('{0, -65536, 0, 0, 0, 0, 1'b1}, 0, '0);
        send_word('{1, -65536, 0, 0, 32'd843314857, 32'd843314857, 1'b0}, 0, '0);
        send_word('{-1, 65536, 0, 0, 32'd1686629713, 0, 1'b0}, 0, '0);
        // Largest tolerances.
        write_reg(CFG_CTOL, 24'hffff);
        write_reg(CFG_ATOL, 24'hffffff);
        send_word('{65535, -3, 0, 0, 0, 0, 1'b0}, 0, '0);
        send_word('{65535, 65535, 0, 0, 0, 0, 1'b0}, 0, '0);
        send_word('{-65536, 65536, 0, 0, 0, 0, 1'b1}, 0, '0);

        // Random phases, each under a fresh tolerance setting.
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_CTOL, 24'd66); write_reg(CFG_ATOL, 24'd268435); end
                1: begin write_reg(CFG_CTOL, 24'd0); write_reg(CFG_ATOL, 24'd0); end
                2: begin write_reg(CFG_CTOL, 24'hffff); write_reg(CFG_ATOL, 24'hffffff); end
                default: begin
                    write_reg(CFG_CTOL, 24'($urandom_range(16'hffff)));
                    write_reg(CFG_ATOL, 24'($urandom_range(24'hffffff)));
                end
            endcase
            no_idle = (ph == 3);
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                w.center_x = rand_coord();
                w.center_y = rand_coord();
                w.point_x = ($urandom_range(3) == 0) ?
                            32'(w.center_x + $signed($urandom_range(70000)) - 35000) :
                            rand_coord();
                w.point_y = rand_coord();
                w.start_angle = rand_angle();
                w.end_angle = rand_angle();
                w.reverse_dir = 1'($urandom_range(1));
                send_word(w, 0, '0);
                sent++;
            end
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (angle_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d output words (%0d on the arc), %0d of them random,",
                 n_words_out, n_hits, sent);
        $display("across six tolerance settings including zero and full scale.");
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
